FILE: design/adcsa_pkg.sv
// ----------------------------------------------------------------------------
// adcsa_pkg: shared definitions for the ADC scan averager
// Register indexes, request opcodes, fixed field widths and sequencer states.
// ----------------------------------------------------------------------------
package adcsa_pkg;

    // Pins with a sample-count register; pins at or above this never scan
    localparam int CFG_PINS        = 4;
    localparam int PIN_W           = 2;
    localparam int MASK_W          = 4;
    localparam int COUNT_W         = 8;
    localparam int READ_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    localparam int DEF_NUM_PINS    = 4;
    localparam int DEF_SAMPLE_BITS = 10;

    // Request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESCAN = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIN_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES3 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: design/adc_scan_average.sv
// ----------------------------------------------------------------------------
// adc_scan_average: round-robin ADC scanner with per-pin oversampling
// Requests are taken only while idle; a request that completes an average
//   runs the divider before its result is loaded into the output register.
// A new request is not taken until the last result is loaded (shared
//   restoring divider, 1 quotient bit per cycle over the SAMPLE_BITS+8 bit
//   sum); a held result stalls the request side.
// Reset: sync active-low aresetn empties the list, clears readings, mask 0.
// ----------------------------------------------------------------------------
//
// Operation
//   A rescan request builds the list of enabled pins in ascending order from
//   the mask register, selects the first entry and arms a discard of the next
//   sample. A sample request adds the conversion into the running sum for the
//   selected pin. When the pin's count is reached the sum is divided by the
//   number of samples taken, the pin's reading counter is bumped and the
//   cursor moves on. A new pin always throws away its first sample, except
//   when the list holds a single pin, which just restarts.
//   Reset also sets all sample counts to 1.
//
// Structure
//   - Step logic evaluated in the accept cycle updates list, cursor, counter,
//     sum and reading counters, and latches the result fields as pending.
//   - A restoring divider (one 9-bit subtract per cycle) produces the average.
//   - A one-entry output register holds the result until the sink takes it.
//   - Configuration writes land at any time; the port is always ready.
//   - Writes to an index past the last sample-count register are dropped.
//
module adc_scan_average #(
    parameter int NUM_PINS    = adcsa_pkg::DEF_NUM_PINS,
    parameter int SAMPLE_BITS = adcsa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adcsa_pkg::CFG_DATA_W-1:0]    cfg_data,

    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [SAMPLE_BITS-1:0]              s_adc_sample,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_active,
    output logic [adcsa_pkg::PIN_W-1:0]         m_mux_pin,
    output logic                                m_pin_changed,
    output logic                                m_done_res,
    output logic [adcsa_pkg::PIN_W-1:0]         m_done_pin,
    output logic [SAMPLE_BITS-1:0]              m_average,
    output logic [adcsa_pkg::READ_W-1:0]        m_reading_count
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    // pins that can ever enter the list
    localparam int LIST_DEPTH = (NUM_PINS < adcsa_pkg::CFG_PINS) ? NUM_PINS
                                                                 : adcsa_pkg::CFG_PINS;
    localparam int LEN_W   = $clog2(LIST_DEPTH + 1);
    localparam int CUR_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SUM_W   = SAMPLE_BITS + adcsa_pkg::COUNT_W;
    localparam int CNT_W   = adcsa_pkg::COUNT_W + 1;   // signed: -1 means discard
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int COUNT_W = adcsa_pkg::COUNT_W;
    localparam int PIN_W   = adcsa_pkg::PIN_W;
    localparam int READ_W  = adcsa_pkg::READ_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [adcsa_pkg::MASK_W-1:0] mask_reg;
    logic [COUNT_W-1:0]           samples_reg [adcsa_pkg::CFG_PINS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            for (int i = 0; i < adcsa_pkg::CFG_PINS; i++) begin
                samples_reg[i] <= COUNT_W'(1);
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == adcsa_pkg::REG_PIN_MASK) begin
                mask_reg <= cfg_data[adcsa_pkg::MASK_W-1:0];
            end else if (cfg_index >= adcsa_pkg::REG_SAMPLES0 &&
                         cfg_index <= adcsa_pkg::REG_SAMPLES3) begin
                samples_reg[PIN_W'(cfg_index - adcsa_pkg::REG_SAMPLES0)] <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------------
    adcsa_pkg::state_t state_reg, state_next;

    logic [PIN_W-1:0]  list_reg  [LIST_DEPTH];   // only entries below len_reg are read
    logic [PIN_W-1:0]  list_next [LIST_DEPTH];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [READ_W-1:0] readings_reg [adcsa_pkg::CFG_PINS];

    // step logic signals
    logic              accept;
    logic [PIN_W-1:0]  mux_before, mux_after;
    logic [PIN_W-1:0]  pin_sel;
    logic [COUNT_W-1:0] count_sel;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LEN_W-1:0]  cur_plus;
    logic [LEN_W-1:0]  fill_idx;
    logic              done_now;
    logic [READ_W-1:0] reading_inc;

    // pending result fields, waiting for the divider and the output register
    logic              pend_active_reg;
    logic [PIN_W-1:0]  pend_mux_reg;
    logic              pend_changed_reg;
    logic              pend_done_reg;
    logic [PIN_W-1:0]  pend_pin_reg;
    logic [READ_W-1:0] pend_count_reg;

    // divider
    logic [COUNT_W-1:0] rem_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   trial_diff;
    logic               trial_fits;
    logic               div_last;

    // output register
    logic               load_out;
    logic               out_valid_reg;

    assign accept = s_valid && s_ready;

    always_comb begin
        list_next   = list_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        done_now    = 1'b0;
        fill_idx    = '0;
        pin_sel     = list_reg[cur_reg];
        mux_before  = (len_reg != '0) ? list_reg[cur_reg] : '0;
        count_sel   = samples_reg[pin_sel];
        if (count_sel == '0) begin
            count_sel = COUNT_W'(1);      // zero count acts as one
        end
        cnt_inc     = cnt_reg + CNT_W'(1);
        cur_plus    = LEN_W'(cur_reg) + LEN_W'(1);
        reading_inc = readings_reg[pin_sel] + READ_W'(1);

        if (s_op == adcsa_pkg::OP_RESCAN) begin
            for (int p = 0; p < LIST_DEPTH; p++) begin
                if (mask_reg[p]) begin
                    list_next[fill_idx[CUR_W-1:0]] = PIN_W'(p);
                    fill_idx = fill_idx + LEN_W'(1);
                end
            end
            len_next = fill_idx;
            cur_next = '0;
            cnt_next = '1;
        end else if (len_reg != '0) begin
            // counter at -1 or 0: start a fresh sum (the -1 sample is tossed later)
            if (cnt_reg[CNT_W-1] || cnt_reg == '0) begin
                sum_next = SUM_W'(s_adc_sample);
            end else begin
                sum_next = sum_reg + SUM_W'(s_adc_sample);
            end
            cnt_next = cnt_inc;
            if (cnt_inc[COUNT_W-1:0] >= count_sel) begin
                done_now = 1'b1;
                cur_next = (cur_plus >= len_reg) ? '0 : cur_plus[CUR_W-1:0];
                cnt_next = (len_reg == LEN_W'(1)) ? '0 : '1;
            end
        end

        mux_after = (len_next != '0) ? list_next[cur_next] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            cur_reg <= '0;
            cnt_reg <= '1;
            sum_reg <= '0;
            for (int i = 0; i < adcsa_pkg::CFG_PINS; i++) begin
                readings_reg[i] <= '0;
            end
        end else if (accept) begin
            len_reg <= len_next;
            cur_reg <= cur_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            if (done_now) begin
                readings_reg[pin_sel] <= reading_inc;
            end
        end
    end

    // list contents and pending fields carry no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            list_reg         <= list_next;
            pend_active_reg  <= (len_next != '0);
            pend_mux_reg     <= mux_after;
            pend_changed_reg <= (mux_after != mux_before);
            pend_done_reg    <= done_now;
            pend_pin_reg     <= done_now ? pin_sel : '0;
            pend_count_reg   <= done_now ? reading_inc : '0;
        end
    end

    // ------------------------------------------------------------------------
    // Restoring divider: sum / sample count, one quotient bit per cycle
    // ------------------------------------------------------------------------
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_fits = (trial >= {1'b0, div_reg});
    assign div_last   = (step_reg == STEP_W'(SUM_W - 1));

    always_ff @(posedge aclk) begin
        if (accept) begin
            rem_reg  <= '0;
            quo_reg  <= sum_next;
            div_reg  <= cnt_inc[COUNT_W-1:0];
            step_reg <= '0;
        end else if (state_reg == adcsa_pkg::ST_DIV) begin
            rem_reg  <= trial_fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], trial_fits};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= adcsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adcsa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = done_now ? adcsa_pkg::ST_DIV : adcsa_pkg::ST_OUT;
                end
            end
            adcsa_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = adcsa_pkg::ST_OUT;
                end
            end
            adcsa_pkg::ST_OUT: begin
                if (load_out) begin
                    state_next = adcsa_pkg::ST_IDLE;
                end
            end
            default: state_next = adcsa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == adcsa_pkg::ST_IDLE);
        load_out = (state_reg == adcsa_pkg::ST_OUT) && (!out_valid_reg || m_ready);
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_active        <= pend_active_reg;
            m_mux_pin       <= pend_mux_reg;
            m_pin_changed   <= pend_changed_reg;
            m_done_res      <= pend_done_reg;
            m_done_pin      <= pend_pin_reg;
            m_average       <= pend_done_reg ? quo_reg[SAMPLE_BITS-1:0] : '0;
            m_reading_count <= pend_count_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

FILE: sim/adc_scan_average_checker.sv
// ----------------------------------------------------------------------------
// adc_scan_average_checker: scoreboard for the ADC scan averager
// Watches the configuration, request and result channels, keeps its own copy
// of the pin list, running sum and per-pin readings, and compares every
// result with the report predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module adc_scan_average_checker #(
    parameter int SMP_W = adcsa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [adcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adcsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_op,
    input  logic [SMP_W-1:0]                    s_adc_sample,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_active,
    input  logic [adcsa_pkg::PIN_W-1:0]         m_mux_pin,
    input  logic                                m_pin_changed,
    input  logic                                m_done_res,
    input  logic [adcsa_pkg::PIN_W-1:0]         m_done_pin,
    input  logic [SMP_W-1:0]                    m_average,
    input  logic [adcsa_pkg::READ_W-1:0]        m_reading_count,
    output int                                  mismatches,
    output int                                  pending
);
    import adcsa_pkg::*;

    localparam int SUM_W = SMP_W + 8;

    typedef struct packed {
        logic               active;
        logic [PIN_W-1:0]   mux_pin;
        logic               pin_changed;
        logic               done_res;
        logic [PIN_W-1:0]   done_pin;
        logic [SMP_W-1:0]   average;
        logic [READ_W-1:0]  reading_count;
    } scan_report_t;

    // register copies
    logic [MASK_W-1:0]  pin_mask;
    logic [COUNT_W-1:0] sample_count [CFG_PINS];

    // scanner state
    logic [PIN_W-1:0]   pin_list [CFG_PINS];
    logic [2:0]         list_len;
    logic [PIN_W-1:0]   cursor;
    int                 samp_cnt;       // -1: next sample is thrown away
    logic [SUM_W-1:0]   acc_sum;
    logic [SMP_W-1:0]   pin_avg [CFG_PINS];
    logic [READ_W-1:0]  pin_reads [CFG_PINS];

    scan_report_t       pending_reports [$];
    int                 mism_cnt = 0;
    int                 report_no;

    assign mismatches = mism_cnt;

    function automatic logic [PIN_W-1:0] selected_pin();
        return (list_len == 0) ? '0 : pin_list[cursor];
    endfunction

    task automatic clear_model();
        pin_mask = '0;
        list_len = '0;
        cursor   = '0;
        samp_cnt = -1;
        acc_sum  = '0;
        for (int p = 0; p < CFG_PINS; p++) begin
            sample_count[p] = COUNT_W'(1);
            pin_list[p]     = '0;
            pin_avg[p]      = '0;
            pin_reads[p]    = '0;
        end
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_PIN_MASK)
            pin_mask = data[MASK_W-1:0];
        else if (idx >= REG_SAMPLES0 && idx <= REG_SAMPLES3)
            sample_count[PIN_W'(idx - REG_SAMPLES0)] = data;
        // anything past the last count register is dropped
    endtask

    function automatic scan_report_t predict_scan(input logic op,
                                                  input logic [SMP_W-1:0] smp);
        scan_report_t     rep;
        logic [PIN_W-1:0] mux_prev;
        logic [PIN_W-1:0] pin;
        int               target;
        rep      = '0;
        mux_prev = selected_pin();
        if (op == OP_RESCAN) begin
            // NUM_PINS equals CFG_PINS here, so every mask bit is a candidate
            list_len = '0;
            for (int p = 0; p < CFG_PINS; p++) begin
                if (pin_mask[p]) begin
                    pin_list[list_len[PIN_W-1:0]] = PIN_W'(p);
                    list_len = list_len + 3'd1;
                end
            end
            cursor   = '0;
            samp_cnt = -1;
        end else if (list_len != 0) begin
            pin = pin_list[cursor];
            // first sample after a discard (or restart) replaces the sum
            if (samp_cnt <= 0)
                acc_sum = SUM_W'(smp);
            else
                acc_sum = acc_sum + SUM_W'(smp);
            samp_cnt++;
            target = (sample_count[pin] == 0) ? 1 : int'(sample_count[pin]);
            if (samp_cnt >= target) begin
                pin_avg[pin]      = SMP_W'(acc_sum / SUM_W'(samp_cnt));
                pin_reads[pin]    = pin_reads[pin] + READ_W'(1);
                rep.done_res      = 1'b1;
                rep.done_pin      = pin;
                rep.average       = pin_avg[pin];
                rep.reading_count = pin_reads[pin];
                if (int'(cursor) + 1 >= int'(list_len))
                    cursor = '0;
                else
                    cursor = cursor + PIN_W'(1);
                samp_cnt = (list_len == 1) ? 0 : -1;
            end
        end
        rep.active      = (list_len != 0);
        rep.mux_pin     = selected_pin();
        rep.pin_changed = (rep.mux_pin != mux_prev);
        return rep;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (mism_cnt < 10)
                $display("result %0d: %s expected %0d, got %0d",
                         report_no, fname, want, got);
            mism_cnt++;
        end
    endtask

    always @(posedge aclk) begin : watch
        scan_report_t want;
        scan_report_t got;
        if (!aresetn) begin
            clear_model();
            pending_reports.delete();
            report_no = 0;
        end else begin
            // a request taken at this edge still sees the old registers
            if (s_valid && s_ready)
                pending_reports.push_back(predict_scan(s_op, s_adc_sample));
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                got.active        = m_active;
                got.mux_pin       = m_mux_pin;
                got.pin_changed   = m_pin_changed;
                got.done_res      = m_done_res;
                got.done_pin      = m_done_pin;
                got.average       = m_average;
                got.reading_count = m_reading_count;
                if (pending_reports.size() == 0) begin
                    if (mism_cnt < 10)
                        $display("result %0d: no request outstanding", report_no);
                    mism_cnt++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("active", 32'(want.active), 32'(got.active));
                    check_field("mux_pin", 32'(want.mux_pin), 32'(got.mux_pin));
                    check_field("pin_changed", 32'(want.pin_changed),
                                32'(got.pin_changed));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    check_field("done_pin", 32'(want.done_pin), 32'(got.done_pin));
                    check_field("average", 32'(want.average), 32'(got.average));
                    check_field("reading_count", 32'(want.reading_count),
                                32'(got.reading_count));
                end
                report_no++;
            end
        end
        pending <= pending_reports.size();
    end

endmodule

FILE: sim/adc_scan_average_tb.sv
// ----------------------------------------------------------------------------
// adc_scan_average_tb: top level for the ADC scan averager
// Drives rescan and sample requests through several pin-mask and sample-count
// settings with random gaps on both sides, and reports the verdict from the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module adc_scan_average_tb;
    import adcsa_pkg::*;

    localparam int SMP_W = DEF_SAMPLE_BITS;
    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    // index past the last count register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // receiver stops taking results for a long stretch once, at this count
    localparam int RX_HOLD_AT     = 300;
    localparam int RX_HOLD_CYCLES = 250;

    // settle time after the last result, longer than a full divide
    localparam int TAIL_CYCLES    = 40;

    logic                       aclk;
    logic                       aresetn;

    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    logic                       s_valid;
    logic                       s_ready;
    logic                       s_op;
    logic [SMP_W-1:0]           s_adc_sample;

    logic                       m_valid;
    logic                       m_ready;
    logic                       m_active;
    logic [PIN_W-1:0]           m_mux_pin;
    logic                       m_pin_changed;
    logic                       m_done_res;
    logic [PIN_W-1:0]           m_done_pin;
    logic [SMP_W-1:0]           m_average;
    logic [READ_W-1:0]          m_reading_count;

    int                         mismatches;
    int                         pending;

    // receiver side
    int                         rx_wait;
    int                         rx_taken;

    adc_scan_average DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_adc_sample    (s_adc_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_active        (m_active),
        .m_mux_pin       (m_mux_pin),
        .m_pin_changed   (m_pin_changed),
        .m_done_res      (m_done_res),
        .m_done_pin      (m_done_pin),
        .m_average       (m_average),
        .m_reading_count (m_reading_count)
    );

    adc_scan_average_checker #(.SMP_W(SMP_W)) scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_adc_sample    (s_adc_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_active        (m_active),
        .m_mux_pin       (m_mux_pin),
        .m_pin_changed   (m_pin_changed),
        .m_done_res      (m_done_res),
        .m_done_pin      (m_done_pin),
        .m_average       (m_average),
        .m_reading_count (m_reading_count),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    // 12-unit clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Result sink. Every taken result may draw a stall of random length.
    // Once, at RX_HOLD_AT, it stops for a long stretch so the output
    // register fills and the block backs up onto the request channel.
    always @(posedge aclk) begin : rx_side
        int gap;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_wait  <= 0;
            rx_taken <= 0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else if (!m_ready) begin
            m_ready <= 1'b1;
        end else if (m_valid) begin
            rx_taken <= rx_taken + 1;
            if (rx_taken == RX_HOLD_AT) begin
                m_ready <= 1'b0;
                rx_wait <= RX_HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    rx_wait <= gap - 1;
                end
            end
        end
    end

    // One request: random gap with valid low, then hold valid and payload
    // until the block takes it. Valid is left high on return so a back-to-back
    // request never drops it.
    task automatic send_req(input logic op, input logic [SMP_W-1:0] smp);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_adc_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Register write; cfg_valid stays high for the caller to drop.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_config(input logic [MASK_W-1:0] mask,
                               input logic [CFG_PINS-1:0][COUNT_W-1:0] counts);
        write_reg(REG_PIN_MASK, CFG_DATA_W'(mask));
        for (int p = 0; p < CFG_PINS; p++)
            write_reg(REG_SAMPLES0 + CFG_IDX_W'(p), counts[p]);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering requests and wait until every result is back; the block
    // is then idle since each request makes exactly one result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Rails show up often; hi pushes toward full scale to stress the sum.
    function automatic logic [SMP_W-1:0] pick_sample(input bit hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (hi && r < 6)
            return SMP_MAX;
        if (r == 0)
            return '0;
        if (r == 1)
            return SMP_MAX;
        return SMP_W'($urandom_range(0, SMP_MAX));
    endfunction

    // Fixed run limit, well above the slowest legal run.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [MASK_W-1:0]                    mask;
        logic [CFG_PINS-1:0][COUNT_W-1:0]     counts;
        int                                   n_items;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_PIN_MASK;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_op         = OP_SAMPLE;
        s_adc_sample = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---

        // empty list after reset: samples are dropped, an all-clear rescan
        // keeps the list empty
        send_req(OP_SAMPLE, SMP_MAX);
        send_req(OP_SAMPLE, '0);
        send_req(OP_RESCAN, '0);
        wait_idle();

        // all four pins; pin 2 gets a zero count, which acts as one.
        // The write past the last count register must not land anywhere.
        write_reg(REG_UNUSED, 8'hA5);
        load_config(4'hF, {8'd3, 8'd0, 8'd2, 8'd1});

        // rotation through all four pins with rail values, including the
        // discard after each pin change
        send_req(OP_RESCAN, '0);
        for (int i = 0; i < 10; i++)
            send_req(OP_SAMPLE, (i % 2 == 0) ? SMP_MAX : '0);

        // new mask without rescan: old list keeps running until the rescan
        wait_idle();
        write_reg(REG_PIN_MASK, 8'h08);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++)
            send_req(OP_SAMPLE, pick_sample(1'b0));

        // single pin: first average discards one sample, later ones restart
        // without a discard and without a mux change
        send_req(OP_RESCAN, SMP_MAX);
        for (int i = 0; i < 7; i++)
            send_req(OP_SAMPLE, (i % 3 == 0) ? SMP_MAX : pick_sample(1'b0));

        // --- random part ---
        // Each phase loads a setting, rescans and then streams mostly samples
        // with the odd rescan thrown in to break up accumulations.
        for (int ph = 0; ph < 12; ph++) begin
            n_items = 110;
            case (ph)
                0: begin
                    mask    = 4'hF;
                    counts  = {4{8'd1}};
                    n_items = 120;
                end
                1: begin
                    // nothing enabled: everything is ignored
                    mask    = 4'h0;
                    counts  = {4{8'd2}};
                    n_items = 30;
                end
                2: begin
                    // longest count on a lone pin, near full-scale sum
                    mask    = 4'b0100;
                    counts  = {4{8'd255}};
                    n_items = 300;
                end
                default: begin
                    mask = MASK_W'($urandom_range(1, 15));
                    for (int p = 0; p < CFG_PINS; p++)
                        counts[p] = ($urandom_range(0, 7) == 7) ? 8'd12 :
                                    COUNT_W'($urandom_range(0, 5));
                end
            endcase

            wait_idle();
            load_config(mask, counts);

            send_req(OP_RESCAN, pick_sample(1'b0));
            for (int i = 1; i < n_items; i++) begin
                // sender pause mid-stream until the pipeline is empty
                if (ph == 4 && i == 60)
                    wait_idle();
                if ($urandom_range(0, 24) == 0)
                    send_req(OP_RESCAN, pick_sample(1'b0));
                else
                    send_req(OP_SAMPLE, pick_sample(ph == 2));
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/adcsa_pkg.sv
design/adc_scan_average.sv
sim/adc_scan_average_checker.sv
sim/adc_scan_average_tb.sv
